// File: hdl/tlbpt_pkg.sv
package tlbpt_pkg;

	localparam int ADDR_W      = 16;
	localparam int PHYS_W      = 15;
	localparam int VPAGE_W     = 8;
	localparam int PAGE_BYTES  = 256;
	localparam int OFFSET_W    = $clog2(PAGE_BYTES);

	localparam int PAGE_COUNT_DEF  = 256;
	localparam int FRAME_COUNT_DEF = 128;
	localparam int TLB_DEPTH_DEF   = 16;

	// controller to datapath
	typedef struct packed {
		logic load;    // latch a new address, start the table reads
		logic commit;  // resolve the lookup, update state, load the result word
	} cmd_t;

endpackage

// File: hdl/tlbpt_ram.sv
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/tlbpt_ctrl.sv
module tlbpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output tlbpt_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE    = 2'b01,
		S_RESOLVE = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		in_stall   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RESOLVE;
				end
			end
			S_RESOLVE: begin
				// hold until the result register is free
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/tlbpt_dp.sv
module tlbpt_dp #(
	parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF,
	parameter int TLB_DEPTH   = tlbpt_pkg::TLB_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlbpt_pkg::cmd_t                cmd,
	input  logic [tlbpt_pkg::ADDR_W-1:0]   logical_address,
	output logic [tlbpt_pkg::PHYS_W-1:0]   physical_address,
	output logic                           tlb_hit,
	output logic                           page_miss,
	output logic                           victim_valid,
	output logic [tlbpt_pkg::VPAGE_W-1:0]  victim_page
);

	localparam int PAGE_W   = $clog2(PAGE_COUNT);
	localparam int FRAME_W  = $clog2(FRAME_COUNT);
	localparam int TLB_W    = $clog2(TLB_DEPTH);
	localparam int OFFSET_W = tlbpt_pkg::OFFSET_W;

	// page number folded into the table range
	logic [11:0]          rem;
	logic [PAGE_W-1:0]    page_in;

	always_comb begin
		rem = {4'b0, logical_address[tlbpt_pkg::ADDR_W-1:OFFSET_W]};
		for (int k = 3; k >= 0; k--) begin
			if (rem >= 12'(PAGE_COUNT << k)) begin
				rem = rem - 12'(PAGE_COUNT << k);
			end
		end
		page_in = PAGE_W'(rem);
	end

	logic [PAGE_W-1:0]    page_s1;
	logic [OFFSET_W-1:0]  offset_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_s1   <= page_in;
			offset_s1 <= logical_address[OFFSET_W-1:0];
		end
	end

	// state
	logic [TLB_DEPTH-1:0]  tlb_valid_q;
	logic [PAGE_W-1:0]     tlb_page_q  [TLB_DEPTH];
	logic [FRAME_W-1:0]    tlb_frame_q [TLB_DEPTH];
	logic [PAGE_COUNT-1:0] present_q;
	logic [TLB_W-1:0]      tlb_next_q;
	logic [FRAME_W-1:0]    next_frame_q;
	logic                  full_q;

	logic [FRAME_W-1:0]    pm_rdata;
	logic [PAGE_W-1:0]     fo_rdata;

	// lookup
	logic [TLB_DEPTH-1:0]  match;
	logic                  hit;
	logic [FRAME_W-1:0]    tlb_frame;
	logic                  present;
	logic                  fault;
	logic                  vvalid;
	logic [FRAME_W-1:0]    frame;
	logic                  fill;

	always_comb begin
		tlb_frame = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			match[i] = tlb_valid_q[i] && (tlb_page_q[i] == page_s1);
			tlb_frame = tlb_frame | (match[i] ? tlb_frame_q[i] : '0);
		end
		hit     = |match;
		present = present_q[page_s1];
		fault   = !hit && !present;
		vvalid  = fault && full_q;
		fill    = cmd.commit && !hit;
		if (hit) begin
			frame = tlb_frame;
		end else if (present) begin
			frame = pm_rdata;
		end else begin
			frame = next_frame_q;
		end
	end

	tlbpt_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (PAGE_COUNT)
	) u_page_map (
		.clk   (clk),
		.we    (cmd.commit && fault),
		.waddr (page_s1),
		.wdata (next_frame_q),
		.re    (cmd.load),
		.raddr (page_in),
		.rdata (pm_rdata)
	);

	tlbpt_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (FRAME_COUNT)
	) u_frame_owner (
		.clk   (clk),
		.we    (cmd.commit && fault),
		.waddr (next_frame_q),
		.wdata (page_s1),
		.re    (cmd.load),
		.raddr (next_frame_q),
		.rdata (fo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_valid_q  <= '0;
			present_q    <= '0;
			tlb_next_q   <= '0;
			next_frame_q <= '0;
			full_q       <= 1'b0;
		end else if (cmd.commit) begin
			// drop the victim before the fill, so the fill wins its slot
			for (int i = 0; i < TLB_DEPTH; i++) begin
				if (vvalid && tlb_valid_q[i] && (tlb_page_q[i] == fo_rdata)) begin
					tlb_valid_q[i] <= 1'b0;
				end
				if (!hit && (TLB_W'(i) == tlb_next_q)) begin
					tlb_valid_q[i] <= 1'b1;
				end
			end
			if (!hit) begin
				tlb_next_q <= (tlb_next_q == TLB_W'(TLB_DEPTH - 1)) ? '0 : tlb_next_q + 1'b1;
			end
			if (vvalid) begin
				present_q[fo_rdata] <= 1'b0;
			end
			if (fault) begin
				present_q[page_s1] <= 1'b1;
				if (next_frame_q == FRAME_W'(FRAME_COUNT - 1)) begin
					next_frame_q <= '0;
					full_q       <= 1'b1;
				end else begin
					next_frame_q <= next_frame_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			tlb_page_q[tlb_next_q]  <= page_s1;
			tlb_frame_q[tlb_next_q] <= frame;
		end
	end

	// result word
	logic [FRAME_W+OFFSET_W-1:0]   phys_full;
	logic [tlbpt_pkg::PHYS_W-1:0]  phys_q;
	logic                          hit_q;
	logic                          fault_q;
	logic                          vvalid_q;
	logic [tlbpt_pkg::VPAGE_W-1:0] vpage_q;

	assign phys_full = {frame, offset_s1};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			phys_q   <= tlbpt_pkg::PHYS_W'(phys_full);
			hit_q    <= hit;
			fault_q  <= fault;
			vvalid_q <= vvalid;
			vpage_q  <= vvalid ? tlbpt_pkg::VPAGE_W'(fo_rdata) : '0;
		end
	end

	assign physical_address = phys_q;
	assign tlb_hit          = hit_q;
	assign page_miss        = fault_q;
	assign victim_valid     = vvalid_q;
	assign victim_page      = vpage_q;

endmodule

// File: hdl/tlb_page_table_translator.sv
// Demand-paging address translator with a fully associative TLB and FIFO
// frame replacement.
// Input channel: in_valid / in_stall carry one logical_address word; the
// upper byte is the page, the lower byte the offset.
// Output channel: out_valid / out_stall carry one result word per input:
// physical_address, tlb_hit, page_miss, victim_valid and victim_page.
// The result word is registered at the edge that ends the resolve cycle,
// which comes after the edge that accepts the input.
// No new word is taken while one resolves. The accepting edge reads the page
// table and frame owner memories; the following resolve cycle compares all
// TLB entries, resolves the translation and writes the memories back.
// A new word is accepted while the previous result still waits to be taken.
// When the receiver stalls with a result held, the block keeps its word in
// the resolve cycle and stops taking input until the output register frees.
// Reset (arst_n low) invalidates the TLB, marks every page not present and
// clears the FIFO pointers; no clearing pass is needed, so input is taken
// as soon as reset is released.
module tlb_page_table_translator #(
	parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF,
	parameter int TLB_DEPTH   = tlbpt_pkg::TLB_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tlbpt_pkg::ADDR_W-1:0]   logical_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tlbpt_pkg::PHYS_W-1:0]   physical_address,
	output logic                           tlb_hit,
	output logic                           page_miss,
	output logic                           victim_valid,
	output logic [tlbpt_pkg::VPAGE_W-1:0]  victim_page
);

	tlbpt_pkg::cmd_t cmd;

	tlbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tlbpt_dp #(
		.PAGE_COUNT  (PAGE_COUNT),
		.FRAME_COUNT (FRAME_COUNT),
		.TLB_DEPTH   (TLB_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.logical_address  (logical_address),
		.physical_address (physical_address),
		.tlb_hit          (tlb_hit),
		.page_miss        (page_miss),
		.victim_valid     (victim_valid),
		.victim_page      (victim_page)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is being resolved");

	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && page_miss))
		else $error("TLB hit and page miss on the same word");

	a_victim_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && victim_valid) |-> page_miss)
		else $error("eviction without a page miss");

	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !victim_valid) |-> (victim_page == '0))
		else $error("victim page not zero without an eviction");

endmodule
